// ===== design/pctd_pkg.sv =====
// Package with shared types, constants and functions of the percent decoder.
`default_nettype none
package pctd_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned UserW = 3;
	localparam int unsigned BufDepth = 2;

	localparam logic [ByteW-1:0] PctChar = 8'h25;
	localparam logic [ByteW-1:0] NulChar = 8'h00;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_ZERO      = 2'd2
	} status_t;

	typedef struct packed {
		logic             ends_string;
		status_t          status;
		logic             has_byte;
		logic [ByteW-1:0] out_byte;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_digit(input logic [ByteW-1:0] c);
		hex_t h;
		h.valid = 1'b1;
		h.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			h.value = 4'(c[2:0] + 3'd1) + 4'd8;
		end else begin
			h.valid = 1'b0;
		end
		return h;
	endfunction

endpackage
`default_nettype wire

// ===== design/pctd_step.sv =====
// Decode step: escape state machine and combinational result for one byte.
`default_nettype none
module pctd_step (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           advance,
	input  wire logic [pctd_pkg::ByteW-1:0]     in_byte,
	input  wire logic                           last_byte,
	output logic                                res_valid,
	output pctd_pkg::result_t                   res
);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_HIGH  = 2'd2,
		PH_DRAIN = 2'd3
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [3:0]          high_q, high_d;
	pctd_pkg::status_t   err_q, err_d;

	pctd_pkg::hex_t      hex;
	logic                fail;
	pctd_pkg::status_t   fail_st;
	logic [pctd_pkg::ByteW-1:0] dec;

	always_comb begin
		hex       = pctd_pkg::hex_digit(in_byte);
		dec       = {high_q, hex.value};
		fail      = 1'b0;
		fail_st   = pctd_pkg::ST_OK;
		res_valid = 1'b0;
		res       = '0;
		phase_d   = phase_q;
		high_d    = high_q;
		err_d     = err_q;
		case (phase_q)
			PH_IDLE: begin
				if (in_byte != pctd_pkg::PctChar) begin
					res_valid       = 1'b1;
					res.out_byte    = in_byte;
					res.has_byte    = 1'b1;
					res.ends_string = last_byte;
				end else if (last_byte) begin
					fail    = 1'b1;
					fail_st = pctd_pkg::ST_MALFORMED;
				end else begin
					phase_d = PH_PCT;
				end
			end
			PH_PCT: begin
				if (!hex.valid || last_byte) begin
					fail    = 1'b1;
					fail_st = pctd_pkg::ST_MALFORMED;
				end else begin
					high_d  = hex.value;
					phase_d = PH_HIGH;
				end
			end
			PH_HIGH: begin
				if (!hex.valid) begin
					fail    = 1'b1;
					fail_st = pctd_pkg::ST_MALFORMED;
				end else if (dec == pctd_pkg::NulChar) begin
					fail    = 1'b1;
					fail_st = pctd_pkg::ST_ZERO;
				end else begin
					phase_d         = PH_IDLE;
					high_d          = 4'd0;
					res_valid       = 1'b1;
					res.out_byte    = dec;
					res.has_byte    = 1'b1;
					res.ends_string = last_byte;
				end
			end
			PH_DRAIN: begin
				if (last_byte) begin
					res_valid       = 1'b1;
					res.status      = err_q;
					res.ends_string = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		if (fail) begin
			res_valid       = 1'b1;
			res.status      = fail_st;
			res.ends_string = last_byte;
			phase_d         = PH_DRAIN;
			err_d           = fail_st;
			high_d          = 4'd0;
		end
		if (last_byte) begin
			phase_d = PH_IDLE;
			high_d  = 4'd0;
			err_d   = pctd_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			high_q  <= 4'd0;
			err_q   <= pctd_pkg::ST_OK;
		end else if (advance) begin
			phase_q <= phase_d;
			high_q  <= high_d;
			err_q   <= err_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/pctd_out_buf.sv =====
// Two-entry result buffer that drives the master-side stream.
`default_nettype none
module pctd_out_buf (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire pctd_pkg::result_t          push_data,
	output logic                            full,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output pctd_pkg::result_t               m_data
);

	localparam int unsigned PtrW = $clog2(pctd_pkg::BufDepth);

	pctd_pkg::result_t  mem_q [pctd_pkg::BufDepth];
	logic [PtrW-1:0]    wr_q, rd_q;
	logic [PtrW:0]      cnt_q;
	logic               pop;

	assign m_tvalid = (cnt_q != '0);
	assign full     = (cnt_q == (PtrW+1)'(pctd_pkg::BufDepth));
	assign pop      = m_tvalid && m_tready;
	assign m_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/percent_decoder.sv =====
// Top level of the streaming percent decoder.
//
//  Channel  Dir  Transfers             Payload
//  s_*      in   one encoded byte      tdata = in_byte, tlast = last_byte
//  m_*      out  zero or one result    tdata = out_byte, tuser = has_byte/status,
//                per input byte        tlast = ends_string
//
// One byte is taken per cycle while the input is not held off; a byte's result
// passes through the input register and then the result buffer to the master side.
// The reset is asynchronous and returns the escape state to idle.
// A stalled output fills the two-entry result buffer; the input is held off
// only when that buffer is full and the waiting byte gives a result.
`default_nettype none
module percent_decoder (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [pctd_pkg::ByteW-1:0] s_tdata,  // [7:0] in_byte
	input  wire logic                       s_tlast,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [pctd_pkg::ByteW-1:0]      m_tdata,  // [7:0] out_byte
	output logic [pctd_pkg::UserW-1:0]      m_tuser,  // [0] has_byte, [2:1] status
	output logic                            m_tlast
);

	logic [pctd_pkg::ByteW-1:0] byte_s1;
	logic                       last_s1;
	logic                       valid_s1;
	logic                       advance;
	logic                       res_valid;
	logic                       buf_full;
	pctd_pkg::result_t          res;
	pctd_pkg::result_t          m_res;

	assign advance  = valid_s1 && (!res_valid || !buf_full);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	pctd_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.in_byte   (byte_s1),
		.last_byte (last_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	pctd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance && res_valid),
		.push_data (res),
		.full      (buf_full),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_data    (m_res)
	);

	assign m_tdata = m_res.out_byte;
	assign m_tuser = {m_res.status, m_res.has_byte};
	assign m_tlast = m_res.ends_string;

endmodule
`default_nettype wire

// ===== design/pctd_checker.sv =====
// Port-level checker for the percent decoder and its bind statement.
`default_nettype none
module pctd_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [pctd_pkg::ByteW-1:0] m_tdata,
	input wire logic [pctd_pkg::UserW-1:0] m_tuser,
	input wire logic                       m_tlast
);

	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("Result changed while stalled.");

	a_nobyte_zero : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == pctd_pkg::NulChar)
		else $error("Result without a byte carries nonzero data.");

	a_err_nobyte : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:1] != pctd_pkg::ST_OK |-> !m_tuser[0])
		else $error("Error result carries a byte.");

	a_status_code : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[2:1] == pctd_pkg::ST_OK
			|| m_tuser[2:1] == pctd_pkg::ST_MALFORMED
			|| m_tuser[2:1] == pctd_pkg::ST_ZERO)
		else $error("Unknown status code.");

	a_byte_nonzero_escape : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tuser[2:1] != pctd_pkg::ST_OK || m_tlast)
		else $error("Byteless ok result not at end of string.");

endmodule

bind percent_decoder pctd_checker u_pctd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

// ===== sim/tb_percent_decoder.sv =====
// Self-checking testbench for the percent decoder with its own decoding predictor.
module tb_percent_decoder;
	import pctd_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_HIGH  = 2'd2,
		PH_DRAIN = 2'd3
	} dec_phase_e;

	typedef struct {
		logic [ByteW-1:0] in_byte;
		logic             last_byte;
		bit               fixed;
		result_t          want;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [ByteW-1:0] s_tdata = '0;
	logic             s_tlast = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [ByteW-1:0] m_tdata;
	logic [UserW-1:0] m_tuser;
	logic             m_tlast;

	dec_phase_e       dec_phase = PH_IDLE;
	logic [3:0]       dec_nibble = 4'd0;
	status_t          dec_err = ST_OK;
	result_t          expected_results[$];
	int               errors = 0;
	int               burst_left = 0;
	int               counted = 0;
	int               ready_left = 0;
	int               ready_mode = 0;
	logic [7:0]       ready_pat = 8'hFF;

	stim_row_t directed_rows[24] = '{
		'{8'h61, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, '{1'b0, ST_OK, 1'b1, 8'h00}},
		'{8'hFF, 1'b0, 1'b1, '{1'b0, ST_OK, 1'b1, 8'hFF}},
		'{8'h25, 1'b0, 1'b0, '0},
		'{8'h34, 1'b0, 1'b0, '0},
		'{8'h31, 1'b0, 1'b0, '0},
		'{8'h25, 1'b0, 1'b0, '0},
		'{8'h66, 1'b0, 1'b0, '0},
		'{8'h46, 1'b0, 1'b1, '{1'b0, ST_OK, 1'b1, 8'hFF}},
		'{8'h25, 1'b0, 1'b0, '0},
		'{8'h30, 1'b0, 1'b0, '0},
		'{8'h30, 1'b0, 1'b1, '{1'b0, ST_ZERO, 1'b0, 8'h00}},
		'{8'h78, 1'b0, 1'b0, '0},
		'{8'h25, 1'b1, 1'b1, '{1'b1, ST_ZERO, 1'b0, 8'h00}},
		'{8'h25, 1'b1, 1'b1, '{1'b1, ST_MALFORMED, 1'b0, 8'h00}},
		'{8'h25, 1'b0, 1'b0, '0},
		'{8'h67, 1'b0, 1'b1, '{1'b0, ST_MALFORMED, 1'b0, 8'h00}},
		'{8'h71, 1'b1, 1'b1, '{1'b1, ST_MALFORMED, 1'b0, 8'h00}},
		'{8'h25, 1'b0, 1'b0, '0},
		'{8'h41, 1'b1, 1'b1, '{1'b1, ST_MALFORMED, 1'b0, 8'h00}},
		'{8'h25, 1'b0, 1'b0, '0},
		'{8'h61, 1'b0, 1'b0, '0},
		'{8'h39, 1'b1, 1'b0, '0},
		'{8'h7A, 1'b1, 1'b1, '{1'b1, ST_OK, 1'b1, 8'h7A}}
	};

	percent_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int hex_value(input logic [ByteW-1:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		return -1;
	endfunction

	function automatic logic [ByteW-1:0] hex_char(input int v, input bit upper);
		if (v < 10) return 8'(8'h30 + v);
		return upper ? 8'(8'h41 + v - 10) : 8'(8'h61 + v - 10);
	endfunction

	function automatic bit fail_escape(input status_t st, input logic last, output result_t r);
		if (last) begin
			dec_phase = PH_IDLE;
			dec_err = ST_OK;
		end else begin
			dec_phase = PH_DRAIN;
			dec_err = st;
		end
		dec_nibble = 4'd0;
		r = '0;
		r.status = st;
		r.ends_string = last;
		return 1'b1;
	endfunction

	// Advances the decoder state by one byte; returns 1 when the byte yields a result.
	function automatic bit decode_byte(input logic [ByteW-1:0] c, input logic last,
			output result_t r);
		int d;
		logic [7:0] v;
		status_t st;
		r = '0;
		r.ends_string = last;
		d = hex_value(c);
		case (dec_phase)
			PH_IDLE: begin
				if (c != PctChar) begin
					r.out_byte = c;
					r.has_byte = 1'b1;
					r.status = ST_OK;
					return 1'b1;
				end
				if (last) return fail_escape(ST_MALFORMED, last, r);
				dec_phase = PH_PCT;
				return 1'b0;
			end
			PH_PCT: begin
				if (d < 0 || last) return fail_escape(ST_MALFORMED, last, r);
				dec_nibble = d[3:0];
				dec_phase = PH_HIGH;
				return 1'b0;
			end
			PH_HIGH: begin
				if (d < 0) return fail_escape(ST_MALFORMED, last, r);
				v = {dec_nibble, d[3:0]};
				if (v == NulChar) return fail_escape(ST_ZERO, last, r);
				dec_phase = PH_IDLE;
				dec_nibble = 4'd0;
				r.out_byte = v;
				r.has_byte = 1'b1;
				r.status = ST_OK;
				return 1'b1;
			end
			default: begin
				if (!last) return 1'b0;
				st = dec_err;
				dec_phase = PH_IDLE;
				dec_nibble = 4'd0;
				dec_err = ST_OK;
				r.status = st;
				return 1'b1;
			end
		endcase
	endfunction

	// Offers one byte, with bursts and random gaps, and returns at its transaction edge.
	task automatic drive_byte(input logic [ByteW-1:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	task automatic send_and_predict(input logic [ByteW-1:0] b, input logic last,
			input bit fixed, input result_t want);
		result_t r;
		bit got;
		counted++;
		drive_byte(b, last);
		got = decode_byte(b, last, r);
		if (fixed) expected_results.push_back(want);
		else if (got) expected_results.push_back(r);
	endtask

	// Builds one random string: mostly plain bytes and valid escapes, some broken ones.
	task automatic send_string();
		logic [ByteW-1:0] str[$];
		int tokens;
		int pick;
		logic [ByteW-1:0] b;
		tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
		if ($urandom_range(0, 9) == 0) begin
			repeat (tokens) begin
				b = ($urandom_range(0, 3) == 0) ? PctChar : 8'($urandom);
				str.push_back(b);
			end
		end else begin
			repeat (tokens) begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					b = 8'($urandom);
					str.push_back(b == PctChar ? 8'h24 : b);
				end else if (pick < 84) begin
					str.push_back(PctChar);
					str.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
					str.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
				end else if (pick < 88) begin
					str.push_back(PctChar);
					str.push_back(8'h30);
					str.push_back(8'h30);
				end else if (pick < 94) begin
					str.push_back(PctChar);
					if ($urandom_range(0, 1)) str.push_back(hex_char($urandom_range(0, 15), 1'b1));
					str.push_back(8'($urandom));
				end else begin
					str.push_back(PctChar);
					if ($urandom_range(0, 1)) str.push_back(hex_char($urandom_range(0, 15), 1'b0));
				end
			end
		end
		foreach (str[i]) send_and_predict(str[i], i == str.size() - 1, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode <= $urandom_range(0, 3);
			ready_left <= $urandom_range(16, 96);
			ready_pat <= 8'($urandom) | 8'h01;
		end else begin
			ready_left <= ready_left - 1;
		end
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: begin
				m_tready <= ready_pat[0];
				if (ready_left != 0) ready_pat <= {ready_pat[0], ready_pat[7:1]};
			end
			default: m_tready <= (ready_left[3:0] == 4'd0);
		endcase
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				errors++;
				$error("unexpected result: out_byte %h tuser %b last %b", m_tdata, m_tuser,
					m_tlast);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata !== want.out_byte) begin
					errors++;
					$error("out_byte: expected %h, actual %h", want.out_byte, m_tdata);
				end
				if (m_tuser[0] !== want.has_byte) begin
					errors++;
					$error("has_byte: expected %b, actual %b", want.has_byte, m_tuser[0]);
				end
				if (m_tuser[2:1] !== want.status) begin
					errors++;
					$error("status: expected %0d, actual %0d", want.status, m_tuser[2:1]);
				end
				if (m_tlast !== want.ends_string) begin
					errors++;
					$error("ends_string: expected %b, actual %b", want.ends_string, m_tlast);
				end
			end
		end
	end

	initial begin
		#400000;
		$display("tb_percent_decoder: errors");
		$finish;
	end

	initial begin
		int wait_cnt;
		bit paused;
		paused = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			send_and_predict(directed_rows[i].in_byte, directed_rows[i].last_byte,
				directed_rows[i].fixed, directed_rows[i].want);
		end
		counted = 0;
		while (counted < 1250) begin
			send_string();
			if (!paused && counted >= 600) begin
				paused = 1'b1;
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (expected_results.size() != 0) @(posedge clk);
				burst_left = 0;
			end
		end
		s_tvalid <= 1'b0;
		wait_cnt = 0;
		while (expected_results.size() != 0 && wait_cnt < 5000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			errors += expected_results.size();
			$error("%0d expected results never arrived", expected_results.size());
		end
		if (errors == 0) begin
			$display("tb_percent_decoder: clean");
		end else begin
			$display("tb_percent_decoder: errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/pctd_pkg.sv
design/pctd_step.sv
design/pctd_out_buf.sv
design/percent_decoder.sv
design/pctd_checker.sv
sim/tb_percent_decoder.sv
